@@ hw/rtl/slcan_pkg.sv @@
// Shared types, constants and the hex decode function for the SLCAN parser.
// No dependencies.
`timescale 1ns / 1ps

package slcan_pkg;

   localparam int unsigned IdWidth      = 12;
   localparam int unsigned PayloadBytes = 8;
   localparam int unsigned CountWidth   = 4;
   localparam int unsigned PosWidth     = 8;

   localparam logic [IdWidth-1:0]  TARGET_ID_RESET = 12'h01C;
   localparam logic [7:0]          CHAR_CR         = 8'h0D;
   localparam logic [7:0]          CHAR_DATA       = 8'h74;   // 't'
   localparam logic [PosWidth-1:0] POS_MAX         = 8'd255;
   localparam logic [PosWidth-1:0] POS_LEN_CHAR    = 8'd4;
   localparam logic [PosWidth-1:0] POS_ID_LAST     = 8'd3;
   localparam logic [PosWidth-1:0] POS_MIN_LINE    = 8'd5;
   localparam logic [CountWidth-1:0] COUNT_FULL    = 4'd8;
   localparam logic [CountWidth-1:0] COUNT_LAST    = 4'd7;

   typedef struct packed {
      logic [23:0]        distance_mm;
      logic [15:0]        amplitude;
      logic [7:0]         quality_pct;
      logic signed [15:0] sensor_status;
   } slcan_fields_type;

   typedef struct packed {
      logic             emit;
      slcan_fields_type fields;
   } slcan_result_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } slcan_hex_type;

   function automatic slcan_hex_type hex_decode(input logic [7:0] c);
      slcan_hex_type r;
      r.is_hex = 1'b1;
      r.value  = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r.value = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         r.value = 4'(c[2:0] + 3'd1) + 4'd8;   // 'a'/'A' low bits 1 -> 10
      end else begin
         r.is_hex = 1'b0;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/slcan_req_if.sv @@
// Input channel interface: one received ASCII character per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface slcan_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/slcan_rsp_if.sv @@
// Result channel interface: one decoded sensor measurement per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface slcan_rsp_if;
   logic               valid;
   logic               ready;
   logic [23:0]        distance_mm;
   logic [15:0]        amplitude;
   logic [7:0]         quality_pct;
   logic signed [15:0] sensor_status;

   modport source (output valid, output distance_mm, output amplitude,
                   output quality_pct, output sensor_status, input ready);
   modport sink   (input valid, input distance_mm, input amplitude,
                   input quality_pct, input sensor_status, output ready);
endinterface

@@ hw/rtl/slcan_line_parser.sv @@
// Per-line parse state, payload byte store and end-of-line frame check.
// Depends on slcan_pkg.
`timescale 1ns / 1ps

module slcan_line_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [7:0]                     rx_byte,
   input  logic [slcan_pkg::IdWidth-1:0]  target_id,
   output slcan_pkg::slcan_result_type    result
);
   import slcan_pkg::*;

   logic [PosWidth-1:0]   pos_ff, pos_in;
   logic                  is_data_ff, is_data_in;
   logic                  bad_ff, bad_in;
   logic [IdWidth-1:0]    id_ff, id_in;
   logic                  pend_ff, pend_in;
   logic [3:0]            hold_ff, hold_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [7:0]            payload_ff [PayloadBytes];
   logic                  wr_en;
   logic [7:0]            wr_data;
   logic [7:0]            byte7;
   logic                  full;
   slcan_hex_type         hx;

   always_comb begin
      hx         = hex_decode(rx_byte);
      pos_in     = pos_ff;
      is_data_in = is_data_ff;
      bad_in     = bad_ff;
      id_in      = id_ff;
      pend_in    = pend_ff;
      hold_in    = hold_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      wr_data    = {hold_ff, hx.value};

      // trailing lone digit lands in the last slot
      full  = (count_ff == COUNT_FULL) || (pend_ff && count_ff == COUNT_LAST);
      byte7 = (count_ff == COUNT_LAST) ? {4'd0, hold_ff} : payload_ff[7];

      result.emit = 1'b0;
      result.fields.distance_mm    = {payload_ff[0], payload_ff[1], payload_ff[2]};
      result.fields.amplitude      = {payload_ff[3], payload_ff[4]};
      result.fields.quality_pct    = payload_ff[5];
      result.fields.sensor_status  = {payload_ff[6], byte7};

      if (rx_byte == CHAR_CR) begin
         result.emit = accept && is_data_ff && (pos_ff >= POS_MIN_LINE) && !bad_ff
                       && (id_ff == target_id) && full;
         pos_in     = '0;
         is_data_in = 1'b0;
         bad_in     = 1'b0;
         id_in      = '0;
         pend_in    = 1'b0;
         hold_in    = '0;
         count_in   = '0;
      end else begin
         if (pos_ff != POS_MAX) pos_in = pos_ff + PosWidth'(1);
         if (pos_ff == '0) begin
            is_data_in = (rx_byte == CHAR_DATA);
         end else if (is_data_ff && pos_ff != POS_LEN_CHAR) begin
            if (!hx.is_hex) begin
               bad_in = 1'b1;
            end else if (pos_ff <= POS_ID_LAST) begin
               id_in = {id_ff[IdWidth-5:0], hx.value};
            end else if (pend_ff) begin
               if (count_ff != COUNT_FULL) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CountWidth'(1);
               end
               pend_in = 1'b0;
            end else begin
               hold_in = hx.value;
               pend_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         is_data_ff <= 1'b0;
         bad_ff     <= 1'b0;
         id_ff      <= '0;
         pend_ff    <= 1'b0;
         hold_ff    <= '0;
         count_ff   <= '0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         is_data_ff <= is_data_in;
         bad_ff     <= bad_in;
         id_ff      <= id_in;
         pend_ff    <= pend_in;
         hold_ff    <= hold_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && wr_en) payload_ff[count_ff[2:0]] <= wr_data;
   end

endmodule

@@ hw/rtl/slcan_rsp_stage.sv @@
// Result register driving the output channel.
// Depends on slcan_pkg and slcan_rsp_if.
`timescale 1ns / 1ps

module slcan_rsp_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  slcan_pkg::slcan_result_type result,
   output logic                        can_load,
   slcan_rsp_if.source                 rsp
);
   import slcan_pkg::*;

   logic             valid_ff;
   slcan_fields_type data_ff;

   assign can_load = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && result.emit) data_ff <= result.fields;
   end

   assign rsp.valid          = valid_ff;
   assign rsp.distance_mm    = data_ff.distance_mm;
   assign rsp.amplitude      = data_ff.amplitude;
   assign rsp.quality_pct    = data_ff.quality_pct;
   assign rsp.sensor_status  = data_ff.sensor_status;

endmodule

@@ hw/rtl/slcan_sensor_frame_parser.sv @@
// SLCAN sensor frame parser: one ASCII character per beat in, one measurement out.
// A result is registered and appears in the cycle after its carriage-return beat is accepted.
// Throughput: 1 character per cycle while ready is high; the line state updates in the accept cycle.
// Ready drops only while a held result waits and the sink is stalled.
// Reset (synchronous, high): line state cleared, target_id back to 0x01C,
// result register empty; payload bytes are not cleared.
`timescale 1ns / 1ps

module slcan_sensor_frame_parser (
   input  logic                          clock,
   input  logic                          reset,
   slcan_req_if.sink                     req_chan,
   slcan_rsp_if.source                   rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [slcan_pkg::IdWidth-1:0] csr_wr_data
);
   import slcan_pkg::*;

   // target_id register; the user must write it only while idle, the block does not enforce it
   logic [IdWidth-1:0] target_id_ff;
   logic               can_load;
   logic               accept;
   slcan_result_type   result;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_id_ff <= TARGET_ID_RESET;
      end else if (csr_wr_en) begin
         target_id_ff <= csr_wr_data;
      end
   end

   // a beat is taken whenever the result register can absorb a possible result
   assign req_chan.ready = can_load;
   assign accept         = req_chan.valid && can_load;

   slcan_line_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_chan.rx_byte),
      .target_id (target_id_ff),
      .result    (result)
   );

   slcan_rsp_stage u_rsp (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .can_load (can_load),
      .rsp      (rsp_chan)
   );

endmodule

@@ bench/slcan_sensor_frame_parser_test.sv @@
// Self-checking bench for slcan_sensor_frame_parser: SLCAN text lines in, sensor readings out.
// Depends on slcan_pkg, slcan_req_if, slcan_rsp_if and slcan_sensor_frame_parser from the RTL.
`timescale 1ns / 1ps

module slcan_sensor_frame_parser_test;
   import slcan_pkg::*;

   localparam int unsigned HalfPeriod  = 10;
   localparam int unsigned HoldCycles  = 400;    // long sink hold-off, fills the block
   localparam int unsigned PhaseBeats  = 300;    // random beats per configuration phase
   localparam int unsigned SettleBeats = 4;      // idle cycles before a register write
   localparam int unsigned MaxReports  = 10;
   localparam logic [7:0]  CHAR_LF     = 8'h0A;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [IdWidth-1:0]   csr_wr_data;

   slcan_req_if req_chan ();
   slcan_rsp_if rsp_chan ();

   slcan_sensor_frame_parser i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   logic [7:0]       char_pending[$];   // characters waiting for the driver
   slcan_fields_type meas_expected[$];  // predicted readings, oldest first
   int               beats_queued;
   int               beats_taken;
   int               phase_items;
   int               error_count;
   int               long_lines;
   bit               req_took;          // input beat accepted at the last rising edge
   bit               no_idle;           // both sides run without gaps
   int               gap_left;
   int               hold_asked;
   int               hold_served;
   int               hold_left;
   int               stall_left;

   // Parser shadow: line state and the target identifier.
   logic [IdWidth-1:0]    match_id;
   logic [PosWidth-1:0]   line_pos;
   bit                    in_frame;
   bit                    frame_bad;
   logic [IdWidth-1:0]    frame_id;
   bit                    half_pending;
   logic [3:0]            half_val;
   logic [CountWidth-1:0] nbytes;
   logic [7:0]            data_bytes[PayloadBytes];

   // ---------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(HalfPeriod) clock = ~clock;
   end

   // Every block input gets a known value at time zero.
   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready   = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Helpers
   // ---------------------------------------------------------------------

   // Gap length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Hex digit value, or -1 for anything that is not 0-9, a-f, A-F.
   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   // ASCII digit for a nibble, letters in random case.
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
   endfunction

   // Any byte but carriage return.
   function automatic logic [7:0] any_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_CR);
      return c;
   endfunction

   // A byte that breaks a hex field without ending the line.
   function automatic logic [7:0] odd_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_CR || hex_nibble(c) >= 0);
      return c;
   endfunction

   task automatic push_char(input logic [7:0] c);
      char_pending = {char_pending, c};
      beats_queued++;
      phase_items++;
   endtask

   // One 't' line: id, unchecked length code, ndig data digits, CR.
   // With make_bad one id or data character is replaced by a non-hex one.
   task automatic add_frame(input logic [IdWidth-1:0] id, input int ndig, input bit make_bad);
      logic [7:0] chars[$];
      int         fill;
      int         spot;
      fill = $urandom_range(0, 9);
      chars = {chars, CHAR_DATA};
      for (int k = 2; k >= 0; k--) chars = {chars, hex_char(id[4*k +: 4])};
      chars = {chars, any_char()};
      for (int k = 0; k < ndig; k++) begin
         chars = {chars, hex_char(fill == 0 ? 4'hF :
                                  fill == 1 ? 4'h0 : 4'($urandom_range(0, 15)))};
      end
      if (make_bad) begin
         spot = $urandom_range(1, 3 + ndig);
         if (spot >= 4) spot++;            // skip the length code
         chars[spot] = odd_char();
      end
      foreach (chars[k]) push_char(chars[k]);
      push_char(CHAR_CR);
   endtask

   // One random line; most are well-formed frames for the current target.
   task automatic add_random_line();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         add_frame(match_id, 16, 1'b0);
      end else if (r < 63) begin
         // trailing lone digit, or extra bytes past the eighth
         add_frame(match_id, $urandom_range(0, 1) ? 15 : $urandom_range(17, 40), 1'b0);
      end else if (r < 70) begin
         // other id: near miss on one bit or fully random
         add_frame($urandom_range(0, 1) ? match_id ^ (12'h1 << $urandom_range(0, 11))
                                        : 12'($urandom_range(0, 4095)),
                   $urandom_range(15, 18), 1'b0);
      end else if (r < 77) begin
         add_frame(match_id, $urandom_range(1, 20), 1'b1);
      end else if (r < 80) begin
         add_frame(match_id, $urandom_range(0, 14), 1'b0);
      end else if (r < 83) begin
         // short line: the 't' and at most three more characters
         push_char(CHAR_DATA);
         n = $urandom_range(0, 3);
         repeat (n) push_char(hex_char(4'($urandom_range(0, 15))));
         push_char(CHAR_CR);
      end else if (r < 88) begin
         // line feed left from the previous line: this is not a data line
         push_char(CHAR_LF);
         add_frame(match_id, 16, 1'b0);
      end else if (r < 95) begin
         n = $urandom_range(0, 30);
         repeat (n) push_char(any_char());
         push_char(CHAR_CR);
      end else if (r < 98 || long_lines >= 3) begin
         push_char(CHAR_CR);
      end else begin
         // position counter runs into saturation
         long_lines++;
         add_frame(match_id, $urandom_range(250, 300), $urandom_range(0, 3) == 0);
      end
   endtask

   // Wait until the block is drained and quiet.
   task automatic wait_idle();
      while (beats_taken != beats_queued || meas_expected.size() != 0) @(negedge clock);
      repeat (SettleBeats) @(negedge clock);
   endtask

   task automatic write_target(input logic [IdWidth-1:0] id);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = id;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= MaxReports) $display("%0t ns: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------
   // Line parser shadow
   // ---------------------------------------------------------------------
   task automatic clear_line();
      line_pos     = '0;
      in_frame     = 1'b0;
      frame_bad    = 1'b0;
      frame_id     = '0;
      half_pending = 1'b0;
      half_val     = '0;
      nbytes       = '0;
   endtask

   // Advance the shadow by one accepted character; a good matching CR
   // queues the reading it produces.
   task automatic parse_char(input logic [7:0] c);
      logic [PosWidth-1:0]   pos;
      logic [CountWidth-1:0] cnt;
      int                    nib;
      slcan_fields_type      meas;
      if (c == CHAR_CR) begin
         cnt = nbytes;
         // a lone last digit still makes a byte
         if (half_pending && cnt < COUNT_FULL) begin
            data_bytes[cnt[2:0]] = {4'h0, half_val};
            cnt++;
         end
         if (in_frame && line_pos >= POS_MIN_LINE && !frame_bad &&
             frame_id == match_id && cnt >= COUNT_FULL) begin
            meas.distance_mm    = {data_bytes[0], data_bytes[1], data_bytes[2]};
            meas.amplitude      = {data_bytes[3], data_bytes[4]};
            meas.quality_pct    = data_bytes[5];
            meas.sensor_status  = {data_bytes[6], data_bytes[7]};
            meas_expected = {meas_expected, meas};
         end
         clear_line();
         return;
      end
      pos = line_pos;
      if (line_pos != POS_MAX) line_pos++;
      if (pos == '0) begin
         in_frame = (c == CHAR_DATA);
         return;
      end
      // length code is never looked at
      if (!in_frame || pos == POS_LEN_CHAR) return;
      nib = hex_nibble(c);
      if (nib < 0) begin
         frame_bad = 1'b1;
         return;
      end
      if (pos <= POS_ID_LAST) begin
         frame_id = {frame_id[IdWidth-5:0], 4'(nib)};
         return;
      end
      if (half_pending) begin
         // bytes past the eighth are checked but dropped
         if (nbytes < COUNT_FULL) begin
            data_bytes[nbytes[2:0]] = {half_val, 4'(nib)};
            nbytes++;
         end
         half_pending = 1'b0;
      end else begin
         half_val     = 4'(nib);
         half_pending = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers queued characters on the falling edge, random gaps.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_took) begin
         if (gap_left > 0) begin
            req_chan.valid <= 1'b0;
            gap_left       <= gap_left - 1;
         end else if (char_pending.size() != 0) begin
            req_chan.valid   <= 1'b1;
            req_chan.rx_byte <= char_pending.pop_front();
            gap_left         <= pick_gap();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sink ready: random stalls, plus a long hold-off on request so the
   // held reading backs up into the input.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served    <= hold_asked;
         hold_left      <= HoldCycles;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left     <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks result beats first, then feeds the accepted input
   // beat to the shadow. A result never belongs to the input beat of the
   // same edge, so this order is safe.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      slcan_fields_type want;
      req_took <= !reset && req_chan.valid && req_chan.ready;
      if (reset) begin
         match_id = TARGET_ID_RESET;
         clear_line();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (meas_expected.size() == 0) begin
               note_error($sformatf("unexpected reading dist=%h amp=%h q=%h st=%h",
                                    rsp_chan.distance_mm, rsp_chan.amplitude,
                                    rsp_chan.quality_pct, rsp_chan.sensor_status));
            end else begin
               want = meas_expected.pop_front();
               if (rsp_chan.distance_mm !== want.distance_mm ||
                   rsp_chan.amplitude !== want.amplitude ||
                   rsp_chan.quality_pct !== want.quality_pct ||
                   rsp_chan.sensor_status !== want.sensor_status) begin
                  note_error($sformatf(
                     "reading mismatch exp dist=%h amp=%h q=%h st=%h got %h %h %h %h",
                     want.distance_mm, want.amplitude, want.quality_pct,
                     want.sensor_status, rsp_chan.distance_mm, rsp_chan.amplitude,
                     rsp_chan.quality_pct, rsp_chan.sensor_status));
               end
            end
         end
         if (csr_wr_en) match_id = csr_wr_data;
         if (req_chan.valid && req_chan.ready) begin
            parse_char(req_chan.rx_byte);
            beats_taken++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Timeout
   // ---------------------------------------------------------------------
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Sequence: reset, directed lines on the reset target, then random
   // phases on several targets including both extremes.
   // ---------------------------------------------------------------------
   initial begin
      logic [IdWidth-1:0] targets[6];
      string              seq;
      targets[0] = 12'hFFF;
      targets[1] = 12'h000;
      targets[2] = 12'($urandom_range(0, 4095));
      targets[3] = TARGET_ID_RESET;             // phase with the long hold-off
      targets[4] = 12'($urandom_range(0, 4095));
      targets[5] = 12'($urandom_range(0, 4095));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset target, lowercase id letter, all-ones distance, zero amplitude,
      // status 0x8007 with a lone trailing digit; then a short line.
      seq = "t01c8FFFFFF0000ff807";
      for (int k = 0; k < seq.len(); k++) push_char(seq[k]);
      push_char(CHAR_CR);
      seq = "t01";
      for (int k = 0; k < seq.len(); k++) push_char(seq[k]);
      push_char(CHAR_CR);

      for (int p = 0; p < 6; p++) begin
         wait_idle();
         write_target(targets[p]);
         no_idle     = (p == 2);
         phase_items = 0;
         if (p == 3) begin
            hold_asked++;
            repeat (8) add_frame(targets[p], 16, 1'b0);
         end
         while (phase_items < PhaseBeats) add_random_line();
      end

      wait_idle();
      repeat (SettleBeats) @(posedge clock);
      if (error_count == 0 && meas_expected.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
